### design/mtet_pkg.sv
// Types and fixed constants shared by the multi-turn encoder tracker.
`timescale 1ns / 1ps

package mtet_pkg;

    // Input item: angle sample or set-zero command
    typedef struct packed {
        logic        kind;
        logic [11:0] raw_angle;
        logic [23:0] elapsed_us;
    } sample_t;

    // Result item
    typedef struct packed {
        logic signed [31:0] multi_turn_angle;
        logic        [11:0] angle_in_turn;
        logic signed [31:0] velocity;
    } result_t;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_ZERO   = 1'b1;

    // Zero elapsed time stands for one millisecond
    localparam logic [23:0] ELAPSED_DEFAULT = 24'd1000;

    // 360 deg * 1e6 us/s * 256 (Q23.8), split at bit 20 for the shared multiplier
    localparam logic [36:0] SCALE_NUM = 37'd92160000000;
    localparam logic [16:0] SCALE_HI  = SCALE_NUM[36:20];
    localparam logic [19:0] SCALE_LO  = SCALE_NUM[19:0];

    // EMA weights, Q0.16
    localparam logic [19:0] W_OLD = 20'd55706;
    localparam logic [19:0] W_NEW = 20'd9830;

    // Shared multiplier: signed A operand, unsigned B operand
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 20;
    localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;

    // Numerator of the speed division: |delta| * SCALE_NUM
    localparam int NUM_W   = 68;
    localparam int NUM_HI_W = NUM_W - 32;
    localparam int PHI_W   = 49;
    localparam int PLO_W   = 52;

    // EMA accumulator widths
    localparam int ACC_W = 48;
    localparam int SUM_W = ACC_W + 1;

endpackage

### design/multi_turn_encoder_tracker.sv
// Multi-turn encoder tracker: turn unwrap, multi-turn angle, smoothed velocity.
//
//  channel  | signals                            | direction
//  ---------+------------------------------------+----------
//  sample   | sample_valid, sample_ready, sample | in
//  result   | result_valid, result_ready, result | out
//
// A sample holds sample_ready low through a 32-step restoring divide for the speed
// plus the setup and filter steps, six of which use one shared 33x20 multiplier.
// A set-zero command skips these steps and goes straight to the output step.
// Exactly one result per input.
// rst_n clears all tracking state and the sequencer; sample_ready is low while
// an item is in work. The result register lets a new item in while the last
// result still waits; the sequencer holds at its final step only if a second
// result would overwrite one not yet taken.
`timescale 1ns / 1ps

module multi_turn_encoder_tracker #(
    parameter int COUNTS_PER_TURN = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  mtet_pkg::sample_t  sample,
    output logic               result_valid,
    input  logic               result_ready,
    output mtet_pkg::result_t  result
);
    import mtet_pkg::*;

    localparam int CPT_W  = $clog2(COUNTS_PER_TURN + 1);
    localparam int DEN_W  = CPT_W + 24;
    localparam int REM_W  = ((DEN_W > NUM_HI_W) ? DEN_W : NUM_HI_W) + 1;
    localparam int CMP_W  = ((CPT_W > 13) ? CPT_W : 13) + 1;
    localparam int ANG_W  = ((CPT_W > 12) ? CPT_W : 12) + 1;
    localparam logic [MUL_B_W-1:0]     CPT_B  = MUL_B_W'(COUNTS_PER_TURN);
    localparam logic signed [CMP_W-1:0] HALF_S = CMP_W'(COUNTS_PER_TURN / 2);
    localparam logic [ANG_W-1:0]       CPT_A  = ANG_W'(COUNTS_PER_TURN);

    // Sequencer codes
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_TOT  = 4'd1;
    localparam logic [3:0] ST_DEN  = 4'd2;
    localparam logic [3:0] ST_MAG  = 4'd3;
    localparam logic [3:0] ST_PHI  = 4'd4;
    localparam logic [3:0] ST_PLO  = 4'd5;
    localparam logic [3:0] ST_NUM  = 4'd6;
    localparam logic [3:0] ST_OVF  = 4'd7;
    localparam logic [3:0] ST_DIV  = 4'd8;
    localparam logic [3:0] ST_EMA1 = 4'd9;
    localparam logic [3:0] ST_EMA2 = 4'd10;
    localparam logic [3:0] ST_SUM  = 4'd11;
    localparam logic [3:0] ST_RND  = 4'd12;
    localparam logic [3:0] ST_OUT  = 4'd13;

    // Control and tracking state (reset)
    logic [3:0]         state_reg, state_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               result_valid_reg, result_valid_next;
    logic [11:0]        last_raw_reg, last_raw_next;
    logic [19:0]        turn_reg, turn_next;
    logic [31:0]        last_total_reg, last_total_next;
    logic signed [31:0] filt_reg, filt_next;
    logic [11:0]        zero_reg, zero_next;

    // Datapath registers (no reset)
    logic [23:0]              el_reg, el_next;
    logic [31:0]              cur_reg, cur_next;
    logic [DEN_W-1:0]         den_reg, den_next;
    logic                     neg_reg, neg_next;
    logic [31:0]              mag_reg, mag_next;
    logic [PHI_W-1:0]         phi_reg, phi_next;
    logic [NUM_W-1:0]         num_reg, num_next;
    logic                     sat_reg, sat_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [31:0]              q_reg, q_next;
    logic signed [31:0]       inst_reg, inst_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    result_t                  result_reg, result_next;

    // Combinational helpers
    logic signed [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic                      accept;
    logic signed [CMP_W-1:0]   diff;
    logic [31:0]               delta;
    logic [NUM_HI_W-1:0]       num_hi;
    logic [31:0]               num_lo;
    logic [REM_W-1:0]          rem_shift;
    logic [REM_W-1:0]          den_ext;
    logic [31:0]               q_cap;
    logic signed [SUM_W-1:0]   rnd;
    logic signed [32:0]        f_val;
    logic [ANG_W-1:0]          ang_wide;
    logic                      out_free;

    assign sample_ready = (state_reg == ST_IDLE);
    assign accept       = sample_valid && sample_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_free     = !result_valid_reg || result_ready;

    assign diff      = CMP_W'($signed({1'b0, sample.raw_angle}))
                     - CMP_W'($signed({1'b0, last_raw_reg}));
    assign delta     = cur_reg - last_total_reg;
    assign num_hi    = num_reg[NUM_W-1:32];
    assign num_lo    = num_reg[31:0];
    assign den_ext   = REM_W'(den_reg);
    assign rem_shift = {rem_reg[REM_W-2:0], num_lo[cnt_reg]};
    assign q_cap     = (sat_reg || (q_reg > 32'h8000_0000)) ? 32'h8000_0000 : q_reg;
    // Round half away from zero: +0.5 for positive sums, +0.5-lsb for negative
    assign rnd       = sum_reg + (sum_reg[SUM_W-1] ? SUM_W'(32767) : SUM_W'(32768));
    assign f_val     = rnd[SUM_W-1:16];
    assign ang_wide  = (last_raw_reg >= zero_reg)
                     ? ANG_W'(last_raw_reg) - ANG_W'(zero_reg)
                     : CPT_A + ANG_W'(last_raw_reg) - ANG_W'(zero_reg);

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_TOT:
            begin
                mul_a = {{(MUL_A_W-20){turn_reg[19]}}, turn_reg};
                mul_b = CPT_B;
            end
            ST_DEN:
            begin
                mul_a = {{(MUL_A_W-24){1'b0}}, el_reg};
                mul_b = CPT_B;
            end
            ST_PHI:
            begin
                mul_a = {1'b0, mag_reg};
                mul_b = MUL_B_W'(SCALE_HI);
            end
            ST_PLO:
            begin
                mul_a = {1'b0, mag_reg};
                mul_b = SCALE_LO;
            end
            ST_EMA1:
            begin
                mul_a = {filt_reg[31], filt_reg};
                mul_b = W_OLD;
            end
            ST_EMA2:
            begin
                mul_a = {inst_reg[31], inst_reg};
                mul_b = W_NEW;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * $signed({1'b0, mul_b});

    // Sequencer and datapath next state
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        result_valid_next = result_valid_reg;
        last_raw_next     = last_raw_reg;
        turn_next         = turn_reg;
        last_total_next   = last_total_reg;
        filt_next         = filt_reg;
        zero_next         = zero_reg;
        el_next           = el_reg;
        cur_next          = cur_reg;
        den_next          = den_reg;
        neg_next          = neg_reg;
        mag_next          = mag_reg;
        phi_next          = phi_reg;
        num_next          = num_reg;
        sat_next          = sat_reg;
        rem_next          = rem_reg;
        q_next            = q_reg;
        inst_next         = inst_reg;
        acc_next          = acc_reg;
        sum_next          = sum_reg;
        result_next       = result_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (sample.kind == KIND_ZERO)
                    begin
                        zero_next       = last_raw_reg;
                        turn_next       = '0;
                        last_total_next = '0;
                        state_next      = ST_OUT;
                    end
                    else
                    begin
                        el_next = (sample.elapsed_us == '0) ? ELAPSED_DEFAULT
                                                            : sample.elapsed_us;
                        // Half-turn jump means the angle wrapped
                        if (diff > HALF_S)
                        begin
                            turn_next = turn_reg - 20'd1;
                        end
                        else if (diff < -HALF_S)
                        begin
                            turn_next = turn_reg + 20'd1;
                        end
                        last_raw_next = sample.raw_angle;
                        state_next    = ST_TOT;
                    end
                end
            end
            ST_TOT:
            begin
                state_next = ST_DEN;
            end
            ST_DEN:
            begin
                // turn * CPT + raw - zero, wrapping in 32 bits
                cur_next   = prod_reg[31:0] + {20'd0, last_raw_reg} - {20'd0, zero_reg};
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                den_next        = prod_reg[DEN_W-1:0];
                neg_next        = delta[31];
                mag_next        = delta[31] ? (~delta + 32'd1) : delta;
                last_total_next = cur_reg;
                state_next      = ST_PHI;
            end
            ST_PHI:
            begin
                state_next = ST_PLO;
            end
            ST_PLO:
            begin
                phi_next   = prod_reg[PHI_W-1:0];
                state_next = ST_NUM;
            end
            ST_NUM:
            begin
                num_next   = NUM_W'({phi_reg, 20'd0}) + NUM_W'(prod_reg[PLO_W-1:0]);
                state_next = ST_OVF;
            end
            ST_OVF:
            begin
                // Upper half not below divisor: quotient needs more than 32 bits
                sat_next   = (REM_W'(num_hi) >= den_ext);
                rem_next   = REM_W'(num_hi);
                q_next     = '0;
                cnt_next   = 5'd31;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // One restoring divide step per cycle
                if (rem_shift >= den_ext)
                begin
                    rem_next = rem_shift - den_ext;
                    q_next   = {q_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift;
                    q_next   = {q_reg[30:0], 1'b0};
                end
                if (cnt_reg == 5'd0)
                begin
                    state_next = ST_EMA1;
                end
                else
                begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            ST_EMA1:
            begin
                if (neg_reg)
                begin
                    inst_next = $signed(~q_cap + 32'd1);
                end
                else
                begin
                    inst_next = (q_cap == 32'h8000_0000) ? 32'sh7FFF_FFFF : $signed(q_cap);
                end
                state_next = ST_EMA2;
            end
            ST_EMA2:
            begin
                acc_next   = prod_reg[ACC_W-1:0];
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                sum_next   = SUM_W'(acc_reg) + SUM_W'($signed(prod_reg[ACC_W-1:0]));
                state_next = ST_RND;
            end
            ST_RND:
            begin
                if (f_val > 33'sh0_7FFF_FFFF)
                begin
                    filt_next = 32'sh7FFF_FFFF;
                end
                else if (f_val < -33'sh0_8000_0000)
                begin
                    filt_next = 32'sh8000_0000;
                end
                else
                begin
                    filt_next = f_val[31:0];
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    result_next.multi_turn_angle = $signed(last_total_reg);
                    result_next.angle_in_turn    = ang_wide[11:0];
                    result_next.velocity         = filt_reg;
                    result_valid_next            = 1'b1;
                    state_next                   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and tracking registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
            last_raw_reg     <= '0;
            turn_reg         <= '0;
            last_total_reg   <= '0;
            filt_reg         <= '0;
            zero_reg         <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
            last_raw_reg     <= last_raw_next;
            turn_reg         <= turn_next;
            last_total_reg   <= last_total_next;
            filt_reg         <= filt_next;
            zero_reg         <= zero_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        el_reg     <= el_next;
        cur_reg    <= cur_next;
        den_reg    <= den_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        phi_reg    <= phi_next;
        num_reg    <= num_next;
        sat_reg    <= sat_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        inst_reg   <= inst_next;
        acc_reg    <= acc_next;
        sum_reg    <= sum_next;
        prod_reg   <= prod_next;
        result_reg <= result_next;
    end

    // Divider remainder must end below the divisor when the quotient fits
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == 5'd0 && !sat_reg) |=> (rem_reg < den_ext))
    else $error("divider remainder not reduced below divisor");

    // Set-zero clears the turn state and latches the last raw angle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sample.kind == KIND_ZERO) |=>
            (turn_reg == '0 && last_total_reg == '0 && zero_reg == last_raw_reg))
    else $error("set-zero did not reset turn state");

    // A new result only appears from the output step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == ST_OUT))
    else $error("result raised outside output step");

endmodule

### tb/sv/multi_turn_encoder_tracker_test.sv
// Self-checking testbench for the multi-turn encoder tracker: turn unwrap, angle and velocity.
`timescale 1ns / 1ps

module multi_turn_encoder_tracker_test;
    import mtet_pkg::*;

    localparam int COUNTS_PER_TURN = 4096;
    localparam int HALF_TURN       = COUNTS_PER_TURN / 2;
    localparam longint SPEED_MAX   = 64'sd2147483647;
    localparam longint SPEED_MIN   = -64'sd2147483648;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    sample_valid = 1'b0;
    logic    sample_ready;
    sample_t sample = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    // Tracker state mirrored for prediction
    logic        [11:0] pos_last_raw = '0;
    logic        [19:0] pos_turns = '0;
    logic        [31:0] pos_last_total = '0;
    logic signed [31:0] pos_speed = '0;
    logic        [11:0] pos_zero = '0;

    result_t expected_readings[$];
    int      error_count = 0;

    // Idle control for the sender and the receiver
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int rx_hold_req = 0;
    int rx_hold_left = 0;
    int rx_stall_left = 0;

    multi_turn_encoder_tracker #(
        .COUNTS_PER_TURN(COUNTS_PER_TURN)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .sample(sample),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Gap length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 10);
        else
            return $urandom_range(20, 70);
    endfunction

    function automatic sample_t make_item(logic kind, logic [11:0] raw, logic [23:0] el);
        sample_t s;
        s.kind       = kind;
        s.raw_angle  = raw;
        s.elapsed_us = el;
        return s;
    endfunction

    // Elapsed time spread over all magnitudes
    function automatic logic [23:0] random_elapsed();
        logic [23:0] v;
        v = 24'($urandom());
        return v >> $urandom_range(0, 23);
    endfunction

    function automatic int pick_velocity();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return int'($urandom_range(0, 80)) - 40;
        else if (r < 85)
            return int'($urandom_range(0, 800)) - 400;
        else if (r < 97)
            return int'($urandom_range(0, 4080)) - 2040;
        else
            return ($urandom_range(0, 1) == 0) ? int'($urandom_range(2048, 2100))
                                                : -int'($urandom_range(2048, 2100));
    endfunction

    // Multi-turn angle from the mirrored turn count, wrapping at 32 bits
    function automatic logic [31:0] multi_turn_position();
        logic [31:0] t;
        t = {{12{pos_turns[19]}}, pos_turns};
        return 32'(t * COUNTS_PER_TURN) + 32'(pos_last_raw) - 32'(pos_zero);
    endfunction

    // Advance the mirrored tracker by one input and return the expected result
    function automatic result_t predict_reading(sample_t item);
        result_t      r;
        logic [23:0]  el;
        int           raw_now;
        int           raw_prev;
        int           jump;
        logic [31:0]  cur;
        logic [31:0]  dwrap;
        logic [31:0]  mag;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        longint       inst;
        longint       old_v;
        longint       w_old;
        longint       w_new;
        longint       acc;
        longint       rounded;
        if (item.kind == KIND_ZERO)
        begin
            pos_zero       = pos_last_raw;
            pos_turns      = '0;
            pos_last_total = '0;
        end
        else
        begin
            el = (item.elapsed_us == '0) ? ELAPSED_DEFAULT : item.elapsed_us;
            raw_now  = int'(item.raw_angle);
            raw_prev = int'(pos_last_raw);
            jump     = raw_now - raw_prev;
            // more than half a turn up means we wrapped backwards, and vice versa
            if (jump > HALF_TURN)
                pos_turns = pos_turns - 20'd1;
            else if (jump < -HALF_TURN)
                pos_turns = pos_turns + 20'd1;
            pos_last_raw = item.raw_angle;

            cur   = multi_turn_position();
            dwrap = cur - pos_last_total;
            mag   = dwrap[31] ? -dwrap : dwrap;

            // instant speed, truncated toward zero, capped at 2^31 magnitude
            num = 128'(mag);
            num = num * SCALE_NUM;
            den = 128'(el);
            den = den * COUNTS_PER_TURN;
            quo = num / den;
            if (quo > 128'h8000_0000)
                quo = 128'h8000_0000;
            inst = longint'(quo[32:0]);
            if (dwrap[31])
                inst = -inst;
            if (inst > SPEED_MAX)
                inst = SPEED_MAX;

            // EMA in Q0.16, round half away from zero
            old_v = longint'(pos_speed);
            w_old = longint'(W_OLD);
            w_new = longint'(W_NEW);
            acc   = old_v * w_old + inst * w_new;
            if (acc >= 0)
                rounded = (acc + 64'sd32768) >>> 16;
            else
                rounded = -((-acc + 64'sd32768) >>> 16);
            if (rounded > SPEED_MAX)
                rounded = SPEED_MAX;
            if (rounded < SPEED_MIN)
                rounded = SPEED_MIN;
            pos_speed      = rounded[31:0];
            pos_last_total = cur;
        end
        r.multi_turn_angle = multi_turn_position();
        // one turn is exactly 12 bits, so the wrap is the 12-bit difference
        r.angle_in_turn    = pos_last_raw - pos_zero;
        r.velocity         = pos_speed;
        return r;
    endfunction

    function automatic void check_reading(result_t got);
        result_t exp_r;
        if (expected_readings.size() == 0)
        begin
            $error("result with no pending input: angle %0d, in-turn %0d, velocity %0d",
                   got.multi_turn_angle, got.angle_in_turn, got.velocity);
            error_count++;
            return;
        end
        exp_r = expected_readings.pop_front();
        if (got.multi_turn_angle !== exp_r.multi_turn_angle)
        begin
            $error("multi_turn_angle: expected %0d, got %0d",
                   exp_r.multi_turn_angle, got.multi_turn_angle);
            error_count++;
        end
        if (got.angle_in_turn !== exp_r.angle_in_turn)
        begin
            $error("angle_in_turn: expected %0d, got %0d",
                   exp_r.angle_in_turn, got.angle_in_turn);
            error_count++;
        end
        if (got.velocity !== exp_r.velocity)
        begin
            $error("velocity: expected %0d, got %0d", exp_r.velocity, got.velocity);
            error_count++;
        end
    endfunction

    // Result side: check each transfer, then decide ready for the next edge
    always @(posedge clk)
    begin
        if (result_valid && result_ready)
            check_reading(result);
        if (rx_hold_req > 0)
        begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            result_ready <= 1'b0;
        end
        else if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 3) == 0)
                rx_stall_left = pick_gap();
        end
    end

    // Offer one input, hold it until the transfer, then record its expected result
    task automatic send_item(input sample_t item);
        int gap;
        gap = (tx_steady || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= item;
        do
            @(posedge clk);
        while (!sample_ready);
        expected_readings.push_back(predict_reading(item));
    endtask

    task automatic wait_all_readings();
        sample_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
    endtask

    // Field extremes, half-turn boundaries, zero elapsed, set-zero handling
    task automatic test_directed_cases();
        // first sample after reset with a large angle counts a turn; zero elapsed
        send_item(make_item(KIND_SAMPLE, 12'd3000, 24'd0));
        send_item(make_item(KIND_SAMPLE, 12'd4095, 24'd1));
        // big negative move in 1 us saturates the instant speed
        send_item(make_item(KIND_SAMPLE, 12'd2048, 24'd1));
        // exactly half a turn down: no turn; longest elapsed time
        send_item(make_item(KIND_SAMPLE, 12'd0, 24'hFF_FFFF));
        send_item(make_item(KIND_SAMPLE, 12'd2049, 24'd1000));
        send_item(make_item(KIND_SAMPLE, 12'd1, 24'd1000));
        send_item(make_item(KIND_SAMPLE, 12'd2050, 24'd1));
        send_item(make_item(KIND_SAMPLE, 12'd0, 24'd1));
        send_item(make_item(KIND_SAMPLE, 12'd4095, 24'd2));
        send_item(make_item(KIND_SAMPLE, 12'd0, 24'd2));
        send_item(make_item(KIND_SAMPLE, 12'd1234, 24'd1000));
        // set-zero ignores its angle and time fields
        send_item(make_item(KIND_ZERO, 12'hFFF, 24'hFF_FFFF));
        // raw below the zero point: in-turn angle wraps
        send_item(make_item(KIND_SAMPLE, 12'd1000, 24'd1000));
        send_item(make_item(KIND_SAMPLE, 12'd4095, 24'd3));
        send_item(make_item(KIND_ZERO, 12'd0, 24'd0));
        send_item(make_item(KIND_ZERO, 12'd77, 24'd5));
        send_item(make_item(KIND_SAMPLE, 12'd0, 24'd1));
        // fast forward rotation drives the filter toward positive saturation
        send_item(make_item(KIND_SAMPLE, 12'd2000, 24'd1));
        send_item(make_item(KIND_SAMPLE, 12'd4000, 24'd1));
        send_item(make_item(KIND_SAMPLE, 12'd1904, 24'd1));
        send_item(make_item(KIND_SAMPLE, 12'd3904, 24'd1));
        send_item(make_item(KIND_SAMPLE, 12'd0, 24'hFF_FFFF));
        wait_all_readings();
    endtask

    // Receiver holds off while inputs keep coming; then sender waits for all results
    task automatic test_back_pressure();
        int i;
        int pos;
        pos = int'(pos_last_raw);
        rx_hold_req = 400;
        tx_steady   = 1'b1;
        for (i = 0; i < 12; i++)
        begin
            pos = (pos + 150) & 12'hFFF;
            send_item(make_item(KIND_SAMPLE, pos[11:0], 24'd1000));
        end
        tx_steady = 1'b0;
        wait_all_readings();
    endtask

    // Mostly smooth rotation with random speed, plus noise and set-zero commands
    task automatic test_random_motion(input int count);
        int          i;
        int          r;
        int          vel;
        int          pos;
        logic [23:0] el;
        sample_t     item;
        pos = $urandom_range(0, 4095);
        vel = 0;
        for (i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
            begin
                tx_steady = ($urandom_range(0, 4) == 0);
                rx_steady = ($urandom_range(0, 4) == 0);
            end
            if (i % 300 == 299)
                wait_all_readings();
            if (i % 40 == 0)
                vel = pick_velocity();
            r = $urandom_range(0, 99);
            if (r < 4)
                item = make_item(KIND_ZERO, 12'($urandom()), 24'($urandom()));
            else if (r < 12)
                item = make_item(KIND_SAMPLE, 12'($urandom()), random_elapsed());
            else
            begin
                pos = (pos + vel + int'($urandom_range(0, 6)) - 3) & 12'hFFF;
                r = $urandom_range(0, 99);
                if (r < 5)
                    el = '0;
                else if (r < 15)
                    el = 24'($urandom_range(1, 64));
                else if (r < 90)
                    el = 24'($urandom_range(200, 5000));
                else
                    el = random_elapsed();
                item = make_item(KIND_SAMPLE, pos[11:0], el);
            end
            send_item(item);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_back_pressure();
        test_random_motion(1260);
        wait_all_readings();
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
